### rtl/gnce_pkg.sv
package gnce_pkg;

  localparam int IDX_W           = 20;
  localparam int CFG_W           = 11;
  localparam int CFG_IDX_W       = 2;
  localparam int NBR_N           = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_RESET       = 1024;
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  // Neighbor slots, dx outer and dy inner, centre left out:
  // bit 0 (-1,-1), 1 (-1,0), 2 (-1,1), 3 (0,-1), 4 (0,1), 5 (1,-1), 6 (1,0), 7 (1,1)
  localparam logic [NBR_N-1:0] NBR_DX_NEG = 8'b0000_0111;
  localparam logic [NBR_N-1:0] NBR_DX_POS = 8'b1110_0000;
  localparam logic [NBR_N-1:0] NBR_DY_NEG = 8'b0010_1001;
  localparam logic [NBR_N-1:0] NBR_DY_POS = 8'b1001_0100;
  // Slots whose offset dx + dy*columns is positive for any row length of two or more
  localparam logic [NBR_N-1:0] NBR_LARGER = 8'b1101_0100;

  typedef enum logic {
    CMD_ALL    = 1'b0,
    CMD_LARGER = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] linear_idx;
    logic             command;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbour_index;
    logic             found;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] centre;
    logic [NBR_N-1:0] nbr_mask;
  } nbr_entry_t;

endpackage

### rtl/gnce_front.sv
module gnce_front #(
  parameter int COL_W = 11,
  parameter int ROW_W = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  gnce_pkg::in_item_t      in_item,
  output logic                    busy,
  input  logic [COL_W-1:0]        cols,
  input  logic [ROW_W-1:0]        rows,
  input  logic                    pop,
  output logic                    push,
  output gnce_pkg::nbr_entry_t    push_entry
);

  localparam int IDX_W = gnce_pkg::IDX_W;
  localparam int CRD_W = $clog2(gnce_pkg::QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] centre;
    logic [COL_W-1:0] rem;
    logic [IDX_W-1:0] quo;
  } div_stage_t;

  div_stage_t          stg_r   [IDX_W];
  div_stage_t          stg_src [IDX_W];
  div_stage_t          stg_nxt [IDX_W];
  logic [COL_W:0]      trial   [IDX_W];
  logic [IDX_W-1:0]    vld_r;
  logic [CRD_W-1:0]    credit_r;
  logic [CRD_W-1:0]    credit_nxt;
  logic                accept;
  div_stage_t          tail;
  logic                in_grid;
  logic                x_lo;
  logic                x_hi;
  logic                y_lo;
  logic                y_hi;
  logic [gnce_pkg::NBR_N-1:0] mask;

  assign accept = start && !busy;
  assign busy   = (credit_r == CRD_W'(gnce_pkg::QUEUE_DEPTH));

  // Restoring divider, one quotient bit per stage
  always_comb begin
    stg_src[0].command = in_item.command;
    stg_src[0].centre  = in_item.linear_idx;
    stg_src[0].rem     = '0;
    stg_src[0].quo     = '0;
    for (int s = 1; s < IDX_W; s++) begin
      stg_src[s] = stg_r[s-1];
    end
    for (int s = 0; s < IDX_W; s++) begin
      trial[s]       = {stg_src[s].rem, stg_src[s].centre[IDX_W-1-s]};
      stg_nxt[s]     = stg_src[s];
      stg_nxt[s].quo = {stg_src[s].quo[IDX_W-2:0], 1'b0};
      if (trial[s] >= {1'b0, cols}) begin
        stg_nxt[s].rem    = COL_W'(trial[s] - {1'b0, cols});
        stg_nxt[s].quo[0] = 1'b1;
      end else begin
        stg_nxt[s].rem = trial[s][COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < IDX_W; s++) begin
      stg_r[s] <= stg_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      credit_r <= '0;
    end else begin
      vld_r    <= {vld_r[IDX_W-2:0], accept};
      credit_r <= credit_nxt;
    end
  end

  always_comb begin
    credit_nxt = credit_r;
    if (accept && !pop) begin
      credit_nxt = credit_r + CRD_W'(1);
    end else if (!accept && pop) begin
      credit_nxt = credit_r - CRD_W'(1);
    end
  end

  // Classify: x is the remainder, y the quotient
  assign tail    = stg_r[IDX_W-1];
  assign in_grid = (cols != '0) && (rows != '0) && (tail.quo < IDX_W'(rows));
  assign x_lo    = (tail.rem == '0);
  assign x_hi    = (tail.rem == cols - COL_W'(1));
  assign y_lo    = (tail.quo == '0);
  assign y_hi    = (tail.quo == IDX_W'(rows) - IDX_W'(1));

  always_comb begin
    mask = ~(({gnce_pkg::NBR_N{x_lo}} & gnce_pkg::NBR_DX_NEG) |
             ({gnce_pkg::NBR_N{x_hi}} & gnce_pkg::NBR_DX_POS) |
             ({gnce_pkg::NBR_N{y_lo}} & gnce_pkg::NBR_DY_NEG) |
             ({gnce_pkg::NBR_N{y_hi}} & gnce_pkg::NBR_DY_POS));
    if (tail.command == gnce_pkg::CMD_LARGER) begin
      mask = mask & gnce_pkg::NBR_LARGER;
    end
    if (!in_grid) begin
      mask = '0;
    end
  end

  assign push                = vld_r[IDX_W-1];
  assign push_entry.centre   = tail.centre;
  assign push_entry.nbr_mask = mask;

endmodule

### rtl/gnce_queue.sv
module gnce_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  gnce_pkg::nbr_entry_t  push_entry,
  input  logic                  pop,
  output logic                  empty,
  output gnce_pkg::nbr_entry_t  head
);

  localparam int DEPTH = gnce_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gnce_pkg::nbr_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;

  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/gnce_emitter.sv
module gnce_emitter #(
  parameter int COL_W = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  gnce_pkg::nbr_entry_t  q_head,
  input  logic [COL_W-1:0]      cols,
  output logic                  pop,
  output logic                  out_valid,
  output gnce_pkg::out_item_t   out_item
);

  localparam int IDX_W = gnce_pkg::IDX_W;
  localparam int NBR_N = gnce_pkg::NBR_N;

  logic                 active_r;
  logic [NBR_N-1:0]     mask_r;
  logic [IDX_W-1:0]     centre_r;
  logic                 out_valid_r;
  gnce_pkg::out_item_t  out_item_r;
  gnce_pkg::out_item_t  out_item_nxt;
  logic [NBR_N-1:0]     sel;
  logic [NBR_N-1:0]     rest;
  logic                 last_now;
  logic [IDX_W-1:0]     cols_x;
  logic [IDX_W-1:0]     row_base;
  logic [IDX_W-1:0]     nbr_idx;

  // Take the lowest pending slot, drop it from the mask
  assign sel      = mask_r & (~mask_r + NBR_N'(1));
  assign rest     = mask_r & (mask_r - NBR_N'(1));
  assign last_now = active_r && (rest == '0);
  assign pop      = !q_empty && (!active_r || last_now);
  assign cols_x   = IDX_W'(cols);

  always_comb begin
    row_base = centre_r;
    if (|(sel & gnce_pkg::NBR_DY_NEG)) begin
      row_base = centre_r - cols_x;
    end else if (|(sel & gnce_pkg::NBR_DY_POS)) begin
      row_base = centre_r + cols_x;
    end
    nbr_idx = row_base;
    if (|(sel & gnce_pkg::NBR_DX_NEG)) begin
      nbr_idx = row_base - IDX_W'(1);
    end else if (|(sel & gnce_pkg::NBR_DX_POS)) begin
      nbr_idx = row_base + IDX_W'(1);
    end
    out_item_nxt.found           = |mask_r;
    out_item_nxt.neighbour_index = (|mask_r) ? nbr_idx : '0;
    out_item_nxt.last            = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      if (pop) begin
        active_r <= 1'b1;
        mask_r   <= q_head.nbr_mask;
        centre_r <= q_head.centre;
      end else if (last_now) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        mask_r <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/grid_neighbour_cell_enumeration.sv
// Moore-neighbor enumerator for a row-major grid. Drive start with a cell index and
// a command while busy is low; the block splits the index into x and y and returns,
// one per cycle on out_valid, the linear indices of the in-grid neighbors in the
// order dx -1..1 outer, dy -1..1 inner (command 1 keeps only larger indices).
// The last result of an item carries last = 1. An index outside the grid, a zero
// size, or no qualifying neighbor gives one result with found = 0. Results cannot
// be held off: sample them on every cycle that out_valid is high. An item gives
// max(1, n) results where n is its neighbor count (up to 8). x and y come from a
// bit-per-stage restoring divider. Four items may be in flight at once; busy rises
// when all four slots are taken, and a slot frees again when the back end takes its
// item from the queue. A steady stream of items with six or more results each keeps
// the output busy every cycle with no gap between items; fewer results per item
// leave gaps.
// Write the size registers only while the block is idle.
module grid_neighbour_cell_enumeration #(
  parameter int MAX_COLUMNS = gnce_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gnce_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  gnce_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output gnce_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gnce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gnce_pkg::CFG_W-1:0]        cfg_data
);

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);

  // Sizes are stored already clamped to the configured maximum
  localparam logic [COL_W-1:0] COLS_RESET =
    COL_W'((gnce_pkg::CFG_RESET > MAX_COLUMNS) ? MAX_COLUMNS : gnce_pkg::CFG_RESET);
  localparam logic [ROW_W-1:0] ROWS_RESET =
    ROW_W'((gnce_pkg::CFG_RESET > MAX_ROWS) ? MAX_ROWS : gnce_pkg::CFG_RESET);

  logic [COL_W-1:0]      cols_r;
  logic [ROW_W-1:0]      rows_r;
  logic [COL_W-1:0]      cols_clamped;
  logic [ROW_W-1:0]      rows_clamped;
  logic                  cfg_write;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_empty;
  gnce_pkg::nbr_entry_t  q_push_entry;
  gnce_pkg::nbr_entry_t  q_head;

  // Register writes are always accepted: cfg_ready is tied high
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign cols_clamped = (32'(cfg_data) > 32'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                           : COL_W'(cfg_data);
  assign rows_clamped = (32'(cfg_data) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
                                                        : ROW_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_write) begin
      unique case (gnce_pkg::cfg_reg_t'(cfg_index))
        gnce_pkg::REG_COLUMNS: begin
          cols_r <= cols_clamped;
        end
        gnce_pkg::REG_ROWS: begin
          rows_r <= rows_clamped;
        end
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Front: accept, divide index by row length, classify neighbor slots
  gnce_front #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .cols       (cols_r),
    .rows       (rows_r),
    .pop        (q_pop),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // Hold classified items until the back end is free
  gnce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back: walk the neighbor mask, one result per cycle
  gnce_emitter #(
    .COL_W (COL_W)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .cols      (cols_r),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### rtl/gnce_checker.sv
module gnce_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input gnce_pkg::out_item_t  out_item
);

  // An empty answer is a single zero result that ends its item
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.last && (out_item.neighbour_index == '0))
    else $error("empty result not a zero last result");

  // Results of one item leave without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("gap inside an item's results");

  // An empty answer follows a completed item, never a partial one
  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found && $past(out_valid) |-> $past(out_item.last))
    else $error("empty result inside another item");

  // Slots are taken only by accepted items
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  // Reset frees every slot
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !busy)
    else $error("busy right after reset");

endmodule

bind grid_neighbour_cell_enumeration gnce_checker u_gnce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
